/* src/cubic_trajectory_interpolator_top_defines.svh */
// ============================================================================
// Assertion macros for the cubic trajectory interpolator
// Concurrent checks, compiled out for synthesis.
// ============================================================================
`ifndef CUBIC_TRAJECTORY_INTERPOLATOR_TOP_DEFINES_SVH
`define CUBIC_TRAJECTORY_INTERPOLATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CTI_ASSERT_NOW(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("cti assertion failed");
// next-cycle implication
`define CTI_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("cti assertion failed");
`else
`define CTI_ASSERT_NOW(label, ck, rn, ante, cons)
`define CTI_ASSERT_NEXT(label, ck, rn, ante, cons)
`endif

`endif

/* src/cti_pkg.sv */
// ============================================================================
// cti_pkg
// Shared constants and types of the cubic trajectory interpolator.
// ============================================================================
package cti_pkg;

    // normalised time tau is unsigned Q1.31
    localparam int FRAC_BITS = 31;
    localparam int Q_W       = FRAC_BITS + 1;
    localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << FRAC_BITS;

    typedef logic [1:0] phase_t;

    localparam phase_t PHASE_BEFORE = 2'd0;
    localparam phase_t PHASE_MOVING = 2'd1;
    localparam phase_t PHASE_DONE   = 2'd2;

    localparam int REG_IDX_W = 1;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    localparam reg_idx_t REG_START_TIME      = 1'd0;
    localparam reg_idx_t REG_MOTION_DURATION = 1'd1;

endpackage

/* src/cti_if.sv */
// ============================================================================
// cti_in_if / cti_out_if
// Valid/ready stream channels for joint samples and commanded positions.
// ============================================================================
interface cti_in_if #(
    parameter int TIME_WIDTH     = 32,
    parameter int POSITION_WIDTH = 32
);
    logic                             valid;
    logic                             ready;
    logic [TIME_WIDTH-1:0]            current_time;
    logic signed [POSITION_WIDTH-1:0] init_position;
    logic signed [POSITION_WIDTH-1:0] goal_position;

    modport source (output valid, current_time, init_position, goal_position, input ready);
    modport sink   (input valid, current_time, init_position, goal_position, output ready);
endinterface

interface cti_out_if #(
    parameter int POSITION_WIDTH = 32
);
    logic                             valid;
    logic                             ready;
    logic signed [POSITION_WIDTH-1:0] position;
    logic [1:0]                       phase;

    modport source (output valid, position, phase, input ready);
    modport sink   (input valid, position, phase, output ready);
endinterface

/* src/cubic_trajectory_interpolator_top.sv */
// ============================================================================
// cubic_trajectory_interpolator_top
// Rest-to-rest cubic position profile, one joint sample per beat.
// ============================================================================
// Pipeline: 1 phase stage, 32 divider stages, 5 arithmetic/output stages.
// Throughput: one beat per cycle.
// Depth is set by the restoring divider for tau, one quotient bit per stage.
// The whole pipeline holds while a result waits and the output is not taken.
// Reset: asynchronous, active low; clears valid bits, start_time to 0 and
// motion_duration to 1.
`include "cubic_trajectory_interpolator_top_defines.svh"

module cubic_trajectory_interpolator_top #(
    parameter int POSITION_WIDTH = 32,
    parameter int TIME_WIDTH     = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [cti_pkg::REG_IDX_W + ((TIME_WIDTH > 32) ? 3 : 2) - 1:0] paddr,
    input  logic [((TIME_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
    output logic [((TIME_WIDTH > 32) ? 64 : 32)-1:0] prdata,
    output logic                     pready,
    cti_in_if.sink                   in_ch,
    cti_out_if.source                out_ch
);
    import cti_pkg::*;

    localparam int PW     = POSITION_WIDTH;
    localparam int TW     = TIME_WIDTH;
    localparam int PDW    = (TW > 32) ? 64 : 32;
    localparam int STR_LG = (TW > 32) ? 3 : 2;
    localparam int ADDR_W = REG_IDX_W + STR_LG;
    localparam int NQ     = Q_W;
    localparam int PRW    = PW + Q_W + 2;

    // ------------------------------------------------------------------ config
    logic [TW-1:0] start_time_reg;
    logic [TW-1:0] motion_duration_reg;
    reg_idx_t      cfg_idx;
    logic          cfg_wr;
    logic [TW-1:0] cfg_data;

    assign pready   = 1'b1;
    assign cfg_idx  = paddr[ADDR_W-1:STR_LG];
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign cfg_data = pwdata[TW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_time_reg      <= '0;
            motion_duration_reg <= TW'(1);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_START_TIME:
                    start_time_reg <= cfg_data;
                REG_MOTION_DURATION:
                    motion_duration_reg <= (cfg_data == '0) ? TW'(1) : cfg_data;
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_START_TIME:      prdata = PDW'(start_time_reg);
            REG_MOTION_DURATION: prdata = PDW'(motion_duration_reg);
            default:             prdata = '0;
        endcase
    end

    // -------------------------------------------------------------- pipe enable
    logic adv;
    logic o_v_reg;

    assign adv         = !o_v_reg || out_ch.ready;
    assign in_ch.ready = adv;

    // -------------------------------------------------- phase stage (index 0)
    logic [TW:0]   end_time;
    phase_t        a_ph_next;
    logic [TW-1:0] a_e_next;

    assign end_time = {1'b0, start_time_reg} + {1'b0, motion_duration_reg};
    assign a_e_next = in_ch.current_time - start_time_reg;

    always_comb
    begin
        if (in_ch.current_time < start_time_reg)
            a_ph_next = PHASE_BEFORE;
        else if ({1'b0, in_ch.current_time} > end_time)
            a_ph_next = PHASE_DONE;
        else
            a_ph_next = PHASE_MOVING;
    end

    // ------------------------------------------- divider chain, stages 1..NQ
    logic [NQ:0]            dv_reg;
    logic [TW-1:0]          dr_reg [NQ+1];
    logic [Q_W-1:0]         dq_reg [NQ+1];
    logic signed [PW-1:0]   di_reg [NQ+1];
    logic signed [PW-1:0]   dg_reg [NQ+1];
    phase_t                 dp_reg [NQ+1];
    logic [TW-1:0]          dr_next [1:NQ];
    logic [Q_W-1:0]         dq_next [1:NQ];

    for (genvar j = 1; j <= NQ; j++)
    begin : g_div
        logic [TW:0] rx;
        logic [TW:0] rs;
        logic        qb;

        if (j == 1)
        begin : g_first
            assign rx = {1'b0, dr_reg[0]};
        end
        else
        begin : g_rest
            assign rx = {dr_reg[j-1], 1'b0};
        end

        assign qb         = rx >= {1'b0, motion_duration_reg};
        assign rs         = rx - {1'b0, motion_duration_reg};
        assign dr_next[j] = qb ? rs[TW-1:0] : rx[TW-1:0];
        assign dq_next[j] = {dq_reg[j-1][Q_W-2:0], qb};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_reg <= '0;
        else if (adv)
            dv_reg <= {dv_reg[NQ-1:0], in_ch.valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dr_reg[0] <= a_e_next;
            dq_reg[0] <= '0;
            di_reg[0] <= in_ch.init_position;
            dg_reg[0] <= in_ch.goal_position;
            dp_reg[0] <= a_ph_next;
            for (int k = 1; k <= NQ; k++)
            begin
                dr_reg[k] <= dr_next[k];
                dq_reg[k] <= dq_next[k];
                di_reg[k] <= di_reg[k-1];
                dg_reg[k] <= dg_reg[k-1];
                dp_reg[k] <= dp_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------- tau^2 stage (M1)
    logic [2*Q_W-1:0]     m1_sq;
    logic                 m1_v_reg;
    logic [Q_W-1:0]       m1_tau_reg;
    logic [Q_W-1:0]       m1_t2_reg;
    logic signed [PW-1:0] m1_i_reg;
    logic signed [PW-1:0] m1_g_reg;
    phase_t               m1_ph_reg;

    assign m1_sq = (2*Q_W)'(dq_reg[NQ]) * (2*Q_W)'(dq_reg[NQ]);

    // ------------------------------------------------------- tau^3 stage (M2)
    logic [2*Q_W-1:0]     m2_cu;
    logic                 m2_v_reg;
    logic [Q_W-1:0]       m2_t2_reg;
    logic [Q_W-1:0]       m2_t3_reg;
    logic signed [PW-1:0] m2_i_reg;
    logic signed [PW-1:0] m2_g_reg;
    phase_t               m2_ph_reg;

    assign m2_cu = (2*Q_W)'(m1_t2_reg) * (2*Q_W)'(m1_tau_reg);

    // ------------------------------------------ blend factor stage (H)
    logic [Q_W+1:0]       h_raw;
    logic [Q_W-1:0]       h_next;
    logic                 h_v_reg;
    logic [Q_W-1:0]       h_reg;
    logic signed [PW:0]   h_diff_reg;
    logic signed [PW-1:0] h_i_reg;
    logic signed [PW-1:0] h_g_reg;
    phase_t               h_ph_reg;

    assign h_raw  = ({2'b00, m2_t2_reg} << 1) + {2'b00, m2_t2_reg}
                  - ({2'b00, m2_t3_reg} << 1);
    assign h_next = (h_raw > (Q_W+2)'(ONE_Q)) ? ONE_Q : h_raw[Q_W-1:0];

    // ------------------------------------------------ scale stage (P)
    logic signed [PRW-1:0] p_prod;
    logic                  p_v_reg;
    logic signed [PRW-1:0] p_prod_reg;
    logic signed [PW-1:0]  p_i_reg;
    logic signed [PW-1:0]  p_g_reg;
    phase_t                p_ph_reg;

    assign p_prod = h_diff_reg * $signed({1'b0, h_reg});

    // ------------------------------------------------ output stage (O)
    logic signed [PRW-1:0] o_sh;
    logic signed [PW-1:0]  o_pos_next;
    logic signed [PW-1:0]  o_pos_reg;
    phase_t                o_ph_reg;

    assign o_sh = p_prod_reg >>> FRAC_BITS;

    always_comb
    begin
        case (p_ph_reg)
            PHASE_BEFORE: o_pos_next = p_i_reg;
            PHASE_DONE:   o_pos_next = p_g_reg;
            default:      o_pos_next = p_i_reg + o_sh[PW-1:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_v_reg <= 1'b0;
            m2_v_reg <= 1'b0;
            h_v_reg  <= 1'b0;
            p_v_reg  <= 1'b0;
            o_v_reg  <= 1'b0;
        end
        else if (adv)
        begin
            m1_v_reg <= dv_reg[NQ];
            m2_v_reg <= m1_v_reg;
            h_v_reg  <= m2_v_reg;
            p_v_reg  <= h_v_reg;
            o_v_reg  <= p_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_tau_reg <= dq_reg[NQ];
            m1_t2_reg  <= m1_sq[FRAC_BITS+Q_W-1:FRAC_BITS];
            m1_i_reg   <= di_reg[NQ];
            m1_g_reg   <= dg_reg[NQ];
            m1_ph_reg  <= dp_reg[NQ];

            m2_t2_reg  <= m1_t2_reg;
            m2_t3_reg  <= m2_cu[FRAC_BITS+Q_W-1:FRAC_BITS];
            m2_i_reg   <= m1_i_reg;
            m2_g_reg   <= m1_g_reg;
            m2_ph_reg  <= m1_ph_reg;

            h_reg      <= h_next;
            h_diff_reg <= (PW+1)'(m2_g_reg) - (PW+1)'(m2_i_reg);
            h_i_reg    <= m2_i_reg;
            h_g_reg    <= m2_g_reg;
            h_ph_reg   <= m2_ph_reg;

            p_prod_reg <= p_prod;
            p_i_reg    <= h_i_reg;
            p_g_reg    <= h_g_reg;
            p_ph_reg   <= h_ph_reg;

            o_pos_reg  <= o_pos_next;
            o_ph_reg   <= p_ph_reg;
        end
    end

    assign out_ch.valid    = o_v_reg;
    assign out_ch.position = o_pos_reg;
    assign out_ch.phase    = o_ph_reg;

    // ------------------------------------------------------------- assertions
    `CTI_ASSERT_NOW(a_tau_range, clk, rst_n,
        dv_reg[NQ] && dp_reg[NQ] == PHASE_MOVING, dq_reg[NQ] <= ONE_Q)
    `CTI_ASSERT_NOW(a_rem_below_div, clk, rst_n,
        dv_reg[NQ] && dp_reg[NQ] == PHASE_MOVING, dr_reg[NQ] < motion_duration_reg)
    `CTI_ASSERT_NOW(a_cube_le_square, clk, rst_n,
        m2_v_reg && m2_ph_reg == PHASE_MOVING, m2_t3_reg <= m2_t2_reg)
    `CTI_ASSERT_NOW(a_stall_blocks_input, clk, rst_n,
        o_v_reg && !out_ch.ready, !in_ch.ready)
    `CTI_ASSERT_NEXT(a_stall_holds_result, clk, rst_n,
        o_v_reg && !out_ch.ready, o_v_reg && $stable(o_pos_reg))

endmodule

/* test/tb_top.sv */
// ============================================================================
// tb_top - cubic trajectory interpolator testbench
// Drives joint samples through the stream input under bursty traffic and
// random output stalls, predicts each commanded position and phase from the
// programmed start time and duration, and checks every result beat in order.
// ============================================================================
module tb_top;
    import cti_pkg::*;

    localparam int          POS_W        = 32;
    localparam int          TIME_W       = 32;
    localparam int          LATENCY      = 38;
    localparam int          HOLD_CYCLES  = 300;
    localparam longint      CYCLE_LIMIT  = 400000;
    localparam logic [31:0] TIME_MAX     = 32'hFFFF_FFFF;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        phase_t                  phase;
    } joint_command_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [REG_IDX_W+1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    cti_in_if  #(.TIME_WIDTH(TIME_W), .POSITION_WIDTH(POS_W)) in_ch ();
    cti_out_if #(.POSITION_WIDTH(POS_W))                      out_ch ();

    cubic_trajectory_interpolator_top #(
        .POSITION_WIDTH (POS_W),
        .TIME_WIDTH     (TIME_W)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    bit [31:0]      cfg_start_time      = 32'd0;
    bit [31:0]      cfg_motion_duration = 32'd1;
    joint_command_t expected_commands[$];
    int             mismatch_count = 0;
    longint         cycle_count    = 0;
    int             burst_left     = 0;
    bit             gaps_enabled   = 1'b1;
    logic           hold_start;
    int             hold_cnt       = 0;
    int             stall_mode     = 0;
    int             stall_run      = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic joint_command_t cubic_position(input logic [31:0] now,
                                                      input logic signed [31:0] init_pos,
                                                      input logic signed [31:0] goal_pos);
        bit [32:0]      end_time;
        bit [63:0]      elapsed;
        bit [63:0]      tau;
        bit [63:0]      tau_sq;
        bit [63:0]      tau_cu;
        bit [63:0]      blend;
        longint         span;
        longint         scaled;
        joint_command_t cmd;
        end_time = {1'b0, cfg_start_time} + {1'b0, cfg_motion_duration};
        if (now < cfg_start_time)
        begin
            cmd.position = init_pos;
            cmd.phase    = PHASE_BEFORE;
        end
        else if ({1'b0, now} > end_time)
        begin
            cmd.position = goal_pos;
            cmd.phase    = PHASE_DONE;
        end
        else
        begin
            elapsed = 64'(now - cfg_start_time);
            tau     = (elapsed << FRAC_BITS) / 64'(cfg_motion_duration);
            if (tau > 64'(ONE_Q))
                tau = 64'(ONE_Q);
            tau_sq = (tau * tau) >> FRAC_BITS;
            tau_cu = (tau_sq * tau) >> FRAC_BITS;
            blend  = 64'd3 * tau_sq - 64'd2 * tau_cu;
            if (blend > 64'(ONE_Q))
                blend = 64'(ONE_Q);
            span         = longint'(goal_pos) - longint'(init_pos);
            scaled       = (span * longint'(blend)) >>> FRAC_BITS;
            cmd.position = 32'(longint'(init_pos) + scaled);
            cmd.phase    = PHASE_MOVING;
        end
        return cmd;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("mismatch %0d: %s got %0d expected %0d", mismatch_count, what, got, want);
    endtask

    // predicted commands are queued on each accepted input beat
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            expected_commands.insert(expected_commands.size(),
                                     cubic_position(in_ch.current_time,
                                                    in_ch.init_position,
                                                    in_ch.goal_position));
    end

    always @(posedge clk)
    begin : check_results
        joint_command_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_commands.size() == 0)
                report_mismatch("unexpected result beat, position", longint'(out_ch.position), 0);
            else
            begin
                want = expected_commands.pop_front();
                if (out_ch.position !== want.position)
                    report_mismatch("position", longint'(out_ch.position), longint'(want.position));
                if (out_ch.phase !== want.phase)
                    report_mismatch("phase", longint'(out_ch.phase), longint'(want.phase));
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_start)
            hold_cnt <= HOLD_CYCLES;
        else if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
    end

    always @(posedge clk)
    begin : stall_pattern
        logic take;
        if (stall_run == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_run  = $urandom_range(16, 200);
        end
        else
            stall_run--;
        case (stall_mode)
            0:       take = 1'b1;
            1:       take = ($urandom_range(0, 3) != 0);
            2:       take = 1'($urandom_range(0, 1));
            default: take = ((cycle_count % 5) != 0);
        endcase
        out_ch.ready <= take && hold_cnt == 0 && !hold_start;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_sample(input logic [31:0] now,
                               input logic signed [31:0] init_pos,
                               input logic signed [31:0] goal_pos);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (gaps_enabled && $urandom_range(0, 3) != 0)
            begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
        burst_left--;
        in_ch.valid         <= 1'b1;
        in_ch.current_time  <= now;
        in_ch.init_position <= init_pos;
        in_ch.goal_position <= goal_pos;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (expected_commands.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == REG_START_TIME)
            cfg_start_time = value;
        else
            cfg_motion_duration = (value == 32'd0) ? 32'd1 : value;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [31:0] start, input logic [31:0] duration);
        drain_results();
        write_register(REG_START_TIME, start);
        write_register(REG_MOTION_DURATION, duration);
    endtask

    function automatic logic signed [31:0] pick_position();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sh0000_0000;
            3:       return 32'shFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // mostly inside the motion window, with some beats either side of it
    task automatic send_random_sample();
        logic [32:0]        end_time;
        logic [32:0]        sum;
        logic [31:0]        now;
        logic [31:0]        offset;
        logic signed [31:0] init_pos;
        logic signed [31:0] goal_pos;
        int unsigned        pick;
        end_time = {1'b0, cfg_start_time} + {1'b0, cfg_motion_duration};
        pick     = $urandom_range(0, 9);
        if ($urandom_range(0, 7) == 0)
            offset = $urandom_range(0, 1) ? cfg_motion_duration : 32'd0;
        else
            offset = $urandom_range(0, cfg_motion_duration);
        sum = {1'b0, cfg_start_time} + {1'b0, offset};
        now = sum[32] ? 32'($urandom_range(cfg_start_time, TIME_MAX)) : sum[31:0];
        if (pick == 0 && cfg_start_time != 0)
            now = $urandom_range(0, cfg_start_time - 1);
        else if (pick == 1 && end_time < {1'b0, TIME_MAX})
            now = $urandom_range(end_time[31:0] + 1, TIME_MAX);
        init_pos = pick_position();
        if ($urandom_range(0, 3) == 0)
            goal_pos = init_pos + $signed(32'($urandom_range(0, 255))) - 32'sd128;
        else
            goal_pos = pick_position();
        send_sample(now, init_pos, goal_pos);
    endtask

    task automatic test_reset_defaults();
        send_sample(32'd0, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_sample(32'd1, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_sample(32'd2, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_sample(TIME_MAX, 32'sh1000_0000, -32'sh1000_0000);
        send_sample(32'd1, 32'sh7FFF_FFFF, 32'sh8000_0000);
    endtask

    task automatic test_phase_boundaries();
        configure(32'd1000, 32'd400);
        send_sample(32'd0, 32'sh0123_4567, -32'sh0765_4321);
        send_sample(32'd999, 32'sh0123_4567, -32'sh0765_4321);
        send_sample(32'd1000, 32'sh0123_4567, -32'sh0765_4321);
        send_sample(32'd1200, 32'sh0123_4567, -32'sh0765_4321);
        send_sample(32'd1400, 32'sh0123_4567, -32'sh0765_4321);
        send_sample(32'd1401, 32'sh0123_4567, -32'sh0765_4321);
    endtask

    // start plus duration past the top of the time range must not wrap
    task automatic test_end_past_time_range();
        configure(TIME_MAX - 32'd10, TIME_MAX);
        send_sample(TIME_MAX, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_sample(TIME_MAX - 32'd11, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_sample(32'd0, 32'sh2000_0000, 32'sh3000_0000);
        configure(TIME_MAX, 32'd1);
        send_sample(TIME_MAX, 32'sh7FFF_FFFF, 32'sh8000_0000);
    endtask

    task automatic test_zero_duration();
        configure(32'd5, 32'd0);
        send_sample(32'd5, 32'sh0000_0100, 32'sh0000_0200);
        send_sample(32'd6, 32'sh0000_0100, 32'sh0000_0200);
        send_sample(32'd7, 32'sh0000_0100, 32'sh0000_0200);
    endtask

    task automatic test_full_span();
        configure(32'd0, TIME_MAX);
        send_sample(TIME_MAX, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_sample(TIME_MAX, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_sample(32'h8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_sample(32'h5555_5555, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_sample(32'hAAAA_AAAA, -32'sh0000_0001, 32'sh0000_0001);
    endtask

    task automatic test_random_profile(input logic [31:0] start, input logic [31:0] duration,
                                       input int count);
        configure(start, duration);
        repeat (count) send_random_sample();
    endtask

    // output held off long enough for the pipeline to fill and stall the input
    task automatic test_output_backpressure();
        configure($urandom(), $urandom_range(1, 5000));
        gaps_enabled = 1'b0;
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        repeat (100) send_random_sample();
        gaps_enabled = 1'b1;
    endtask

    initial
    begin
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        hold_start          = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.current_time  = '0;
        in_ch.init_position = '0;
        in_ch.goal_position = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_phase_boundaries();
        test_end_past_time_range();
        test_zero_duration();
        test_full_span();
        test_random_profile(32'd0, 32'd1, 120);
        test_random_profile(32'd0, TIME_MAX, 140);
        test_random_profile($urandom(), $urandom_range(1, 64), 140);
        test_random_profile($urandom(), $urandom(), 140);
        test_random_profile(TIME_MAX, TIME_MAX, 80);
        test_random_profile($urandom_range(0, 100000), $urandom_range(1000, 1000000), 130);
        test_output_backpressure();

        drain_results();
        repeat (LATENCY + 20) @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
